@@ rtl/core/s2c_pkg.sv @@
// constants, tables and helpers for the spherical to cartesian converter
`timescale 1ns / 1ps
package s2c_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  // number of rotation stages actually built
  localparam int CORDIC_ITER  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES :
                                (CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS;

  localparam int ANG_W   = 16;
  localparam int RAD_W   = 16;
  localparam int COORD_W = 17;
  localparam int CW      = 33;  // cordic datapath width
  localparam int TRIG_W  = 32;  // clamped sine and cosine
  localparam int H_W     = 34;  // horizontal length
  localparam int ZP_W    = 49;  // radius times trig product
  localparam int XP_W    = 66;  // horizontal length times trig product

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic signed [CW-1:0] HALF_PI     = 33'sh0_4000_0000;
  localparam logic signed [CW-1:0] PI_UNITS    = 33'sh0_8000_0000;
  localparam logic signed [CW-1:0] ONE_Q30     = 33'sh0_4000_0000;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 16'sd16384;
  localparam logic signed [19:0] COORD_LIMIT = 20'sd65535;

  localparam logic signed [ZP_W-1:0] ROUND_H  = 49'sd1 <<< 13;
  localparam logic signed [ZP_W-1:0] ROUND_Z  = 49'sd1 <<< 29;
  localparam logic signed [XP_W-1:0] ROUND_XY = 66'sd1 <<< 45;

  // arctangent of 2^-i, 2^31 equals pi
  localparam logic signed [CW-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    33'sh0_2000_0000, 33'sh0_12E4_051E, 33'sh0_09FB_385B, 33'sh0_0511_11D4,
    33'sh0_028B_0D43, 33'sh0_0145_D7E1, 33'sh0_00A2_F61E, 33'sh0_0051_7C55,
    33'sh0_0028_BE53, 33'sh0_0014_5F2F, 33'sh0_000A_2F98, 33'sh0_0005_17CC,
    33'sh0_0002_8BE6, 33'sh0_0001_45F3, 33'sh0_0000_A2FA, 33'sh0_0000_517D,
    33'sh0_0000_28BE, 33'sh0_0000_145F, 33'sh0_0000_0A30, 33'sh0_0000_0518,
    33'sh0_0000_028C, 33'sh0_0000_0146, 33'sh0_0000_00A3, 33'sh0_0000_0051
  };

  // negate on fold, then limit to plus or minus one in q2.30
  function automatic logic signed [TRIG_W-1:0] trig_limit(
    input logic signed [CW-1:0] v,
    input logic                 flip
  );
    logic signed [CW-1:0] t;
    t = flip ? -v : v;
    if (t > ONE_Q30) begin
      t = ONE_Q30;
    end else if (t < -ONE_Q30) begin
      t = -ONE_Q30;
    end
    return t[TRIG_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] coord_limit(
    input logic signed [19:0] v
  );
    logic signed [19:0] t;
    t = v;
    if (t > COORD_LIMIT) begin
      t = COORD_LIMIT;
    end else if (t < -COORD_LIMIT) begin
      t = -COORD_LIMIT;
    end
    return t[COORD_W-1:0];
  endfunction

endpackage

@@ rtl/core/spherical_to_cartesian_core.sv @@
// spherical to cartesian converter: twin cordic pipelines and multiplier stages
`timescale 1ns / 1ps
// Converts (radius, azimuth, elevation) into signed q17.0 x, y and z in radius units.
// Input stream: in_tvalid/in_tready/in_tdata, one position per transaction.
// Output stream: out_tvalid/out_tready/out_tdata, one coordinate triple per
// input transaction, delivered in order.
// Angles are 16-bit binary angles (32768 = pi); elevation is measured from
// the equator. Sine and cosine of both angles come from two rotation-mode
// cordic chains, one register stage per rotation, running side by side.
// Throughput: one transaction per cycle, sustained while out_tready stays high.
// Pipeline, in order, from acceptance to out_tvalid: an input fold stage,
// the rotation chain, a limit stage, two multiplier stages and the output
// register. The rotation chain is the longest part of it.
// Reset (rst_n low, synchronous) empties the pipeline; results in flight are
// dropped and none is invented, since the block holds no state between transactions.
// When out_tready is low the output register holds its data; each stage
// still takes new data while it is empty, so bubbles close up and
// in_tready drops only once every stage holds a transaction.
module spherical_to_cartesian_core
  import s2c_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] radius, [31:16] azimuth_angle, [47:32] elevation_angle
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [16:0] coord_x, [33:17] coord_y, [50:34] coord_z, [55:51] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int N = CORDIC_ITER;

  logic [RAD_W-1:0]        in_radius;
  logic signed [ANG_W-1:0] in_az, in_el;

  assign in_radius = in_tdata[15:0];
  assign in_az     = in_tdata[31:16];
  assign in_el     = in_tdata[47:32];

  // rotation chain, stage 0 holds the folded input
  logic [N:0]              v_r;
  logic [N:0]              en;
  logic signed [CW-1:0]    ax_r [0:N];
  logic signed [CW-1:0]    ay_r [0:N];
  logic signed [CW-1:0]    az_r [0:N];
  logic signed [CW-1:0]    ex_r [0:N];
  logic signed [CW-1:0]    ey_r [0:N];
  logic signed [CW-1:0]    ez_r [0:N];
  logic                    aflip_r [0:N];
  logic                    eflip_r [0:N];
  logic [RAD_W-1:0]        rad_r [0:N];

  logic                    cl_v_r, p1_v_r, p2_v_r, out_v_r;
  logic                    cl_en, p1_en, p2_en, out_en;

  logic signed [TRIG_W-1:0] ca_r, sa_r, ce_r, se_r;
  logic [RAD_W-1:0]         cl_rad_r;
  logic signed [TRIG_W-1:0] p1_ca_r, p1_sa_r;
  logic signed [H_W-1:0]    h_r;
  logic signed [ZP_W-1:0]   zp_r;
  logic signed [XP_W-1:0]   xp_r, yp_r;
  logic signed [COORD_W-1:0] p2_z_r;
  logic signed [COORD_W-1:0] x_r, y_r, z_r;

  logic signed [CW-1:0]    az_fold, el_fold;
  logic                    az_flip, el_flip;
  logic signed [ZP_W-1:0]  hp_nxt, zp_nxt, h_sum, z_sum;
  logic signed [XP_W-1:0]  xp_nxt, yp_nxt, x_sum, y_sum;

  // stall chain: a stage loads when empty or when its successor moves on
  assign out_en = !out_v_r || out_tready;
  assign p2_en  = !p2_v_r || out_en;
  assign p1_en  = !p1_v_r || p2_en;
  assign cl_en  = !cl_v_r || p1_en;
  assign en[N]  = !v_r[N] || cl_en;
  for (genvar k = 0; k < N; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_tready = en[0];

  // fold angles beyond a quarter turn into range, flipping the signs later
  always_comb begin
    az_flip = (in_az > QUARTER_TURN) || (in_az < -QUARTER_TURN);
    el_flip = (in_el > QUARTER_TURN) || (in_el < -QUARTER_TURN);
    az_fold = {in_az[ANG_W-1], in_az, 16'd0};
    el_fold = {in_el[ANG_W-1], in_el, 16'd0};
    if (az_flip) begin
      az_fold = in_az[ANG_W-1] ? az_fold + PI_UNITS : az_fold - PI_UNITS;
    end
    if (el_flip) begin
      el_fold = in_el[ANG_W-1] ? el_fold + PI_UNITS : el_fold - PI_UNITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax_r[0]    <= CORDIC_GAIN;
      ay_r[0]    <= '0;
      az_r[0]    <= az_fold;
      ex_r[0]    <= CORDIC_GAIN;
      ey_r[0]    <= '0;
      ez_r[0]    <= el_fold;
      aflip_r[0] <= az_flip;
      eflip_r[0] <= el_flip;
      rad_r[0]   <= in_radius;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en[i+1]) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        if (az_r[i] >= 0) begin
          ax_r[i+1] <= ax_r[i] - (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] + (ax_r[i] >>> i);
          az_r[i+1] <= az_r[i] - ATAN_TABLE[i];
        end else begin
          ax_r[i+1] <= ax_r[i] + (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] - (ax_r[i] >>> i);
          az_r[i+1] <= az_r[i] + ATAN_TABLE[i];
        end
        if (ez_r[i] >= 0) begin
          ex_r[i+1] <= ex_r[i] - (ey_r[i] >>> i);
          ey_r[i+1] <= ey_r[i] + (ex_r[i] >>> i);
          ez_r[i+1] <= ez_r[i] - ATAN_TABLE[i];
        end else begin
          ex_r[i+1] <= ex_r[i] + (ey_r[i] >>> i);
          ey_r[i+1] <= ey_r[i] - (ex_r[i] >>> i);
          ez_r[i+1] <= ez_r[i] + ATAN_TABLE[i];
        end
        aflip_r[i+1] <= aflip_r[i];
        eflip_r[i+1] <= eflip_r[i];
        rad_r[i+1]   <= rad_r[i];
      end
    end
  end

  // multiplier stage inputs and rounding sums
  always_comb begin
    hp_nxt = $signed({1'b0, cl_rad_r}) * ce_r;
    zp_nxt = $signed({1'b0, cl_rad_r}) * se_r;
    h_sum  = hp_nxt + ROUND_H;
    xp_nxt = h_r * p1_ca_r;
    yp_nxt = h_r * p1_sa_r;
    z_sum  = zp_r + ROUND_Z;
    x_sum  = xp_r + ROUND_XY;
    y_sum  = yp_r + ROUND_XY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cl_en) begin
        cl_v_r <= v_r[N];
      end
      if (p1_en) begin
        p1_v_r <= cl_v_r;
      end
      if (p2_en) begin
        p2_v_r <= p1_v_r;
      end
      if (out_en) begin
        out_v_r <= p2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cl_en) begin
      ca_r     <= trig_limit(ax_r[N], aflip_r[N]);
      sa_r     <= trig_limit(ay_r[N], aflip_r[N]);
      ce_r     <= trig_limit(ex_r[N], eflip_r[N]);
      se_r     <= trig_limit(ey_r[N], eflip_r[N]);
      cl_rad_r <= rad_r[N];
    end
    if (p1_en) begin
      h_r     <= h_sum[47:14];
      zp_r    <= zp_nxt;
      p1_ca_r <= ca_r;
      p1_sa_r <= sa_r;
    end
    if (p2_en) begin
      xp_r   <= xp_nxt;
      yp_r   <= yp_nxt;
      p2_z_r <= coord_limit({z_sum[48], z_sum[48:30]});
    end
    if (out_en) begin
      x_r <= coord_limit(x_sum[65:46]);
      y_r <= coord_limit(y_sum[65:46]);
      z_r <= p2_z_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, z_r, y_r, x_r};

  // an empty output stage never holds back the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input stalled with an empty output register");

  // a stalled output holds back every stage behind it only when all are full
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && cl_v_r && p1_v_r && p2_v_r && out_v_r && !out_tready)
    else $error("input stalled while a pipeline stage was empty");

  // limited azimuth cosine and elevation sine stay within plus or minus one
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    cl_v_r |-> ca_r <= $signed(ONE_Q30[TRIG_W-1:0]) && ca_r >= -$signed(ONE_Q30[TRIG_W-1:0])
            && se_r <= $signed(ONE_Q30[TRIG_W-1:0]) && se_r >= -$signed(ONE_Q30[TRIG_W-1:0]))
    else $error("trig value out of range");

  // every coordinate delivered lies within the saturation limit
  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> x_r != -17'sd65536 && y_r != -17'sd65536 && z_r != -17'sd65536)
    else $error("coordinate beyond saturation limit");

  // reset empties the output register
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_v_r)
    else $error("output valid after reset");

endmodule
